// ===== design/plr_pkg.sv =====
// Shared types and constants for the patterned line rasterizer.
// No dependencies; used by every module of the block.
package plr_pkg;

	localparam int DOT_PERIOD  = 15;
	localparam int DASH_PERIOD = 20;
	localparam int DOT_BITS    = 4;
	localparam int DASH_BITS   = 5;

	typedef enum logic [1:0] {
		MODE_PLAIN  = 2'd0,
		MODE_DASHED = 2'd1,
		MODE_DOTTED = 2'd2,
		MODE_THICK  = 2'd3
	} pattern_mode_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_STEP = 1'b1
	} cmd_t;

	typedef struct packed {
		logic dir_x_neg;
		logic dir_y_neg;
		logic axes_swapped;
	} line_flags_t;

	typedef struct packed {
		logic plot;
		logic thick;
		logic last;
	} pix_flags_t;

endpackage

// ===== design/patterned_line_rasterizer.sv =====
// Patterned Bresenham line rasterizer, top level: line state and result register.
// Depends on plr_pkg, plr_setup and plr_step.
//
// Input channel (in_valid/in_ready): cmd selects a load of new endpoints
// (x_start..y_end) or one pixel step along the major axis. A load gives no
// item out; a step with no active line gives none either and changes nothing.
// Output channel (out_valid/out_ready): pixel_x, pixel_y, plot, thick, last,
// one item per step of an active line, appearing in the cycle after the step
// is accepted. The start point is never emitted; the last step gives the end point.
// Throughput is one item per cycle: the line state updates combinationally
// through plr_step, and an input is taken whenever the result register is
// empty or is being drained in the same cycle. When the receiver stalls with
// a result waiting, in_ready drops until it is taken.
// Config channel (cfg_valid/cfg_ready/pattern_mode) is always ready; write it
// only while no line is stepping. Takes effect on the next step.
// Reset clears the line state (no line active), the mode to plain and
// the output valid.
module patterned_line_rasterizer #(
	parameter int COORD_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    pattern_mode,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic signed [COORD_BITS-1:0]  x_start,
	input  logic signed [COORD_BITS-1:0]  y_start,
	input  logic signed [COORD_BITS-1:0]  x_end,
	input  logic signed [COORD_BITS-1:0]  y_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_BITS-1:0]  pixel_x,
	output logic signed [COORD_BITS-1:0]  pixel_y,
	output logic                          plot,
	output logic                          thick,
	output logic                          last
);
	import plr_pkg::*;

	pattern_mode_t mode_q;
	logic [COORD_BITS-1:0] cur_x_q, cur_y_q;
	logic signed [COORD_BITS+2:0] error_q;
	logic [COORD_BITS:0] steps_q, major_q, minor_q;
	line_flags_t flags_q;
	logic blank_q;
	logic [DOT_BITS-1:0] mod15_q;
	logic [DASH_BITS-1:0] mod20_q;

	logic out_valid_q;
	logic [COORD_BITS-1:0] pix_x_q, pix_y_q;
	pix_flags_t pix_q;

	logic [COORD_BITS:0] ld_major, ld_minor;
	logic signed [COORD_BITS+2:0] ld_error;
	line_flags_t ld_flags;

	logic st_active, st_blank;
	logic [COORD_BITS-1:0] st_x, st_y;
	logic signed [COORD_BITS+2:0] st_error;
	logic [COORD_BITS:0] st_steps;
	logic [DOT_BITS-1:0] st_mod15;
	logic [DASH_BITS-1:0] st_mod20;
	pix_flags_t st_pix;

	logic accept, do_load, do_step;

	plr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.major_len  (ld_major),
		.minor_len  (ld_minor),
		.error_init (ld_error),
		.flags      (ld_flags)
	);

	plr_step #(.COORD_BITS(COORD_BITS)) u_step (
		.cur_x       (cur_x_q),
		.cur_y       (cur_y_q),
		.error_term  (error_q),
		.steps_done  (steps_q),
		.major_len   (major_q),
		.minor_len   (minor_q),
		.flags       (flags_q),
		.blank_phase (blank_q),
		.mod15_count (mod15_q),
		.mod20_count (mod20_q),
		.mode        (mode_q),
		.active      (st_active),
		.next_x      (st_x),
		.next_y      (st_y),
		.next_error  (st_error),
		.next_steps  (st_steps),
		.next_blank  (st_blank),
		.next_mod15  (st_mod15),
		.next_mod20  (st_mod20),
		.pix         (st_pix)
	);

	assign cfg_ready = 1'b1;
	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;
	assign do_load = accept && (cmd == CMD_LOAD);
	assign do_step = accept && (cmd == CMD_STEP) && st_active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			cur_x_q <= '0;
			cur_y_q <= '0;
			error_q <= '0;
			steps_q <= '0;
			major_q <= '0;
			minor_q <= '0;
			flags_q <= '0;
			blank_q <= 1'b0;
			mod15_q <= '0;
			mod20_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				mode_q <= pattern_mode_t'(pattern_mode);
			if (do_load) begin
				cur_x_q <= x_start;
				cur_y_q <= y_start;
				error_q <= ld_error;
				steps_q <= '0;
				major_q <= ld_major;
				minor_q <= ld_minor;
				flags_q <= ld_flags;
				blank_q <= 1'b0;
				mod15_q <= '0;
				mod20_q <= '0;
			end else if (do_step) begin
				cur_x_q <= st_x;
				cur_y_q <= st_y;
				error_q <= st_error;
				steps_q <= st_steps;
				blank_q <= st_blank;
				mod15_q <= st_mod15;
				mod20_q <= st_mod20;
			end
			if (do_step)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			pix_x_q <= st_x;
			pix_y_q <= st_y;
			pix_q <= st_pix;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x = pix_x_q;
	assign pixel_y = pix_y_q;
	assign plot = pix_q.plot;
	assign thick = pix_q.thick;
	assign last = pix_q.last;

endmodule

// ===== design/plr_setup.sv =====
// Line setup for a load item: axis lengths, directions, swap flag, error term.
// Depends on plr_pkg.
module plr_setup #(
	parameter int COORD_BITS = 12
) (
	input  logic signed [COORD_BITS-1:0] x_start,
	input  logic signed [COORD_BITS-1:0] y_start,
	input  logic signed [COORD_BITS-1:0] x_end,
	input  logic signed [COORD_BITS-1:0] y_end,
	output logic [COORD_BITS:0]          major_len,
	output logic [COORD_BITS:0]          minor_len,
	output logic signed [COORD_BITS+2:0] error_init,
	output plr_pkg::line_flags_t         flags
);
	import plr_pkg::*;

	localparam int LW = COORD_BITS + 1;
	localparam int EW = COORD_BITS + 3;

	logic signed [LW-1:0] dx, dy;
	logic [LW-1:0] adx, ady;
	logic swap;

	always_comb begin
		dx = LW'(x_end) - LW'(x_start);
		dy = LW'(y_end) - LW'(y_start);
		adx = dx[LW-1] ? LW'(-dx) : LW'(dx);
		ady = dy[LW-1] ? LW'(-dy) : LW'(dy);
		swap = ady > adx;
		major_len = swap ? ady : adx;
		minor_len = swap ? adx : ady;
		error_init = EW'({minor_len, 1'b0}) - EW'(major_len);
		flags.dir_x_neg = !(x_start < x_end);
		flags.dir_y_neg = !(y_start < y_end);
		flags.axes_swapped = swap;
	end

endmodule

// ===== design/plr_step.sv =====
// One Bresenham step with pattern decision, from the registered line state.
// Depends on plr_pkg.
module plr_step #(
	parameter int COORD_BITS = 12
) (
	input  logic [COORD_BITS-1:0]           cur_x,
	input  logic [COORD_BITS-1:0]           cur_y,
	input  logic signed [COORD_BITS+2:0]    error_term,
	input  logic [COORD_BITS:0]             steps_done,
	input  logic [COORD_BITS:0]             major_len,
	input  logic [COORD_BITS:0]             minor_len,
	input  plr_pkg::line_flags_t            flags,
	input  logic                            blank_phase,
	input  logic [plr_pkg::DOT_BITS-1:0]    mod15_count,
	input  logic [plr_pkg::DASH_BITS-1:0]   mod20_count,
	input  plr_pkg::pattern_mode_t          mode,
	output logic                            active,
	output logic [COORD_BITS-1:0]           next_x,
	output logic [COORD_BITS-1:0]           next_y,
	output logic signed [COORD_BITS+2:0]    next_error,
	output logic [COORD_BITS:0]             next_steps,
	output logic                            next_blank,
	output logic [plr_pkg::DOT_BITS-1:0]    next_mod15,
	output logic [plr_pkg::DASH_BITS-1:0]   next_mod20,
	output plr_pkg::pix_flags_t             pix
);
	import plr_pkg::*;

	localparam int EW = COORD_BITS + 3;

	logic e_ge, x_move, y_move;
	logic [COORD_BITS-1:0] sx, sy;
	logic [DOT_BITS-1:0] m15_inc;
	logic [DASH_BITS-1:0] m20_inc;

	always_comb begin
		e_ge = !error_term[EW-1];
		x_move = flags.axes_swapped ? e_ge : 1'b1;
		y_move = flags.axes_swapped ? 1'b1 : e_ge;
		sx = flags.dir_x_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
		sy = flags.dir_y_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
		next_x = x_move ? cur_x + sx : cur_x;
		next_y = y_move ? cur_y + sy : cur_y;
		next_error = error_term + EW'({minor_len, 1'b0})
			- (e_ge ? EW'({major_len, 1'b0}) : EW'(0));

		active = steps_done < major_len;
		next_steps = steps_done + (COORD_BITS+1)'(1);

		m15_inc = mod15_count + DOT_BITS'(1);
		m20_inc = mod20_count + DASH_BITS'(1);
		next_mod15 = (m15_inc == DOT_BITS'(DOT_PERIOD)) ? '0 : m15_inc;
		next_mod20 = (m20_inc == DASH_BITS'(DASH_PERIOD)) ? '0 : m20_inc;

		next_blank = blank_phase;
		pix.thick = 1'b0;
		pix.last = next_steps == major_len;
		unique case (mode)
			MODE_PLAIN: begin
				pix.plot = 1'b1;
			end
			MODE_THICK: begin
				pix.plot = 1'b1;
				pix.thick = 1'b1;
			end
			default: begin
				// dashed falls through to the dotted rule off the dash point
				if (mode == MODE_DASHED && next_mod20 == '0) begin
					pix.plot = 1'b1;
				end else begin
					if (next_mod15 == '0)
						next_blank = !blank_phase;
					pix.plot = !next_blank;
				end
			end
		endcase
	end

endmodule
